/* rtl/stl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants for the stereo tremolo
// Holds the sequencer states, register indexes, oscillator shape codes and
// the function that builds the sine table at elaboration.
// ----------------------------------------------------------------------------
package stl_pkg;

    // Fixed-point constants
    localparam int          GAIN_W      = 17;                 // Q1.16, 0..1.0
    localparam logic [16:0] ONE_Q16     = 17'h10000;
    localparam int          DEPTH_W     = 16;
    localparam int          STEP_W      = 23;
    localparam int          SHAPE_W     = 2;
    localparam int          CFG_INDEX_W = 2;
    localparam int          CFG_DATA_W  = 23;
    localparam int          MUL_B_W     = GAIN_W + 1;         // signed gain operand

    // Sine table geometry
    localparam int SINE_DEPTH = 256;
    localparam int SINE_IDX_W = $clog2(SINE_DEPTH);

    // Oscillator shape codes (code 3 behaves as square)
    localparam logic [SHAPE_W-1:0] WAVE_SINE     = 2'd0;
    localparam logic [SHAPE_W-1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [SHAPE_W-1:0] WAVE_SQUARE   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SHAPE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BYPASS     = 2'd3;

    // Register reset values
    localparam logic [SHAPE_W-1:0] WAVE_SHAPE_RST = WAVE_SINE;
    localparam logic [DEPTH_W-1:0] DEPTH_RST      = 16'd45875;
    localparam logic [STEP_W-1:0]  PHASE_STEP_RST = 23'd1695;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LFO,
        ST_GAIN_MUL,
        ST_GAIN_SUB,
        ST_LEFT_MUL,
        ST_RIGHT_MUL,
        ST_STORE,
        ST_DONE
    } stl_state_t;

    // Operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MUL_DEPTH,
        MUL_LEFT,
        MUL_RIGHT
    } stl_mul_sel_t;

    // Control word from the sequencer to the datapath
    typedef struct packed {
        logic         s_ready;
        stl_mul_sel_t mul_sel;
        logic         lfo_load;
        logic         gain_load;
        logic         left_load;
        logic         right_load;
        logic         phase_adv;
        logic         out_load;
    } stl_ctrl_t;

    // sin(pi/2 * q) in Q30 for q in Q30, odd polynomial of degree 9.
    // Only evaluated on constants while the table is built.
    function automatic logic [63:0] quarter_sine(input logic [63:0] q);
        logic [63:0] q2;
        logic [63:0] t;
        q2 = (q * q) >> 30;
        t  = 64'd172272;
        t  = 64'd5026995    - ((q2 * t) >> 30);
        t  = 64'd85569306   - ((q2 * t) >> 30);
        t  = 64'd693598669  - ((q2 * t) >> 30);
        t  = 64'd1686629713 - ((q2 * t) >> 30);
        t  = (q * t) >> 30;
        return (t > (64'd1 << 30)) ? (64'd1 << 30) : t;
    endfunction

    // Table entry k: (1 + sin(2*pi*k/D)) / 2 in Q16, limited to 0..1.0.
    function automatic logic [16:0] sine_entry(input logic [63:0] k);
        logic [63:0] u;
        logic [63:0] quad;
        logic [63:0] frac;
        logic [63:0] q;
        logic [63:0] s;
        logic [63:0] v;
        u    = (k << 32) / SINE_DEPTH;
        quad = (u >> 30) & 64'd3;
        frac = u & ((64'd1 << 30) - 64'd1);
        q    = quad[0] ? ((64'd1 << 30) - frac) : frac;
        s    = quarter_sine(q);
        v    = quad[1] ? ((64'd1 << 30) - s) : ((64'd1 << 30) + s);
        v    = (v + (64'd1 << 14)) >> 15;
        return (v > 64'h10000) ? ONE_Q16 : v[16:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/stereo_tremolo_lfo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_tremolo_lfo: stereo tremolo driven by a low-frequency oscillator
// Multiplies both samples of a pair by 1 - depth*(1-lfo)/2 and advances the
// oscillator phase by one step per pair; bypass passes pairs and holds the phase.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_*       in         left_sample, right_sample (signed SAMPLE_WIDTH each)
//  m_*       out        left_out, right_out (signed SAMPLE_WIDTH each)
//  cfg_*     in         register index and write data
//
//  A pair steps through LFO, GAIN_MUL, GAIN_SUB, LEFT_MUL, RIGHT_MUL, STORE
//  and DONE to the output register; all three multiplications (gain, left,
//  right) go through one shared multiplier. In bypass a pair goes from idle
//  straight to DONE. The next pair is accepted once the sequencer is back in
//  idle, so a pair is finished before the next is taken; a result that is not
//  taken stalls the sequencer in its last state.
//  aresetn clears the phase and output valid and resets state and config registers.
// ----------------------------------------------------------------------------
module stereo_tremolo_lfo #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int PHASE_WIDTH  = 24
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: left_sample, right_sample, zero fill
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // m_tdata: left_out, right_out, zero fill
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [stl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [stl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import stl_pkg::*;

    localparam int DATA_W  = ((2*SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int MUL_A_W = SAMPLE_WIDTH + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    stl_state_t state_reg, state_next;
    stl_ctrl_t  ctrl;

    logic [SHAPE_W-1:0]      wave_shape_reg;
    logic [DEPTH_W-1:0]      depth_reg;
    logic [STEP_W-1:0]       phase_step_reg;
    logic                    bypass_reg;
    logic [PHASE_WIDTH-1:0]  phase_reg;
    logic [PHASE_WIDTH-1:0]  step_ext;

    logic [SAMPLE_WIDTH-1:0] left_in_reg, right_in_reg;
    logic [SAMPLE_WIDTH-1:0] left_res_reg, right_res_reg;
    logic [SAMPLE_WIDTH-1:0] left_out_reg, right_out_reg;
    logic                    m_tvalid_reg;

    logic [GAIN_W-1:0]        lfo;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;

    logic s_beat;
    logic out_free;

    assign s_beat    = s_tvalid & s_tready;
    assign out_free  = ~m_tvalid_reg | m_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_shape_reg <= WAVE_SHAPE_RST;
            depth_reg      <= DEPTH_RST;
            phase_step_reg <= PHASE_STEP_RST;
            bypass_reg     <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WAVE_SHAPE: wave_shape_reg <= cfg_data[SHAPE_W-1:0];
                REG_DEPTH:      depth_reg      <= cfg_data[DEPTH_W-1:0];
                REG_PHASE_STEP: phase_step_reg <= cfg_data[STEP_W-1:0];
                REG_BYPASS:     bypass_reg     <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    state_next = bypass_reg ? ST_DONE : ST_LFO;
                end
            end
            ST_LFO:       state_next = ST_GAIN_MUL;
            ST_GAIN_MUL:  state_next = ST_GAIN_SUB;
            ST_GAIN_SUB:  state_next = ST_LEFT_MUL;
            ST_LEFT_MUL:  state_next = ST_RIGHT_MUL;
            ST_RIGHT_MUL: state_next = ST_STORE;
            ST_STORE:     state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        ctrl = '0;
        ctrl.mul_sel = MUL_DEPTH;
        unique case (state_reg)
            ST_IDLE:      ctrl.s_ready = 1'b1;
            ST_LFO:       ctrl.lfo_load = 1'b1;
            ST_GAIN_MUL:  ctrl.mul_sel = MUL_DEPTH;
            ST_GAIN_SUB:  ctrl.gain_load = 1'b1;
            ST_LEFT_MUL:  ctrl.mul_sel = MUL_LEFT;
            ST_RIGHT_MUL: begin
                ctrl.mul_sel   = MUL_RIGHT;
                ctrl.left_load = 1'b1;
            end
            ST_STORE: begin
                ctrl.right_load = 1'b1;
                ctrl.phase_adv  = 1'b1;
            end
            ST_DONE:      ctrl.out_load = out_free;
            default:      ;
        endcase
    end

    assign s_tready = ctrl.s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Oscillator value for the current phase
    stl_lfo #(
        .PHASE_WIDTH(PHASE_WIDTH)
    ) u_lfo (
        .aclk       (aclk),
        .phase      (phase_reg),
        .wave_shape (wave_shape_reg),
        .load       (ctrl.lfo_load),
        .lfo        (lfo)
    );

    // Shared multiplier operands
    always_comb begin
        unique case (ctrl.mul_sel)
            MUL_LEFT: begin
                mul_a = {left_in_reg[SAMPLE_WIDTH-1], left_in_reg};
                mul_b = {1'b0, gain_reg};
            end
            MUL_RIGHT: begin
                mul_a = {right_in_reg[SAMPLE_WIDTH-1], right_in_reg};
                mul_b = {1'b0, gain_reg};
            end
            default: begin
                mul_a = {{(MUL_A_W-DEPTH_W){1'b0}}, depth_reg};
                mul_b = {1'b0, ONE_Q16 - lfo};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Gain: 1 - depth*(1-lfo)/2, truncated
    always_ff @(posedge aclk) begin
        if (ctrl.gain_load) begin
            gain_reg <= ONE_Q16 - {1'b0, prod_reg[DEPTH_W+GAIN_W-1:GAIN_W]};
        end
    end

    // Input samples and scaled results (floor of product / 2^16)
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            left_in_reg  <= s_tdata[SAMPLE_WIDTH-1:0];
            right_in_reg <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        end
        if (s_beat && bypass_reg) begin
            left_res_reg  <= s_tdata[SAMPLE_WIDTH-1:0];
            right_res_reg <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
        end else begin
            if (ctrl.left_load) begin
                left_res_reg <= prod_reg[SAMPLE_WIDTH+15:16];
            end
            if (ctrl.right_load) begin
                right_res_reg <= prod_reg[SAMPLE_WIDTH+15:16];
            end
        end
    end

    // Phase accumulator, wraps modulo one cycle
    if (PHASE_WIDTH > STEP_W) begin : g_step_wide
        assign step_ext = {{(PHASE_WIDTH-STEP_W){1'b0}}, phase_step_reg};
    end else begin : g_step_narrow
        assign step_ext = phase_step_reg[PHASE_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (ctrl.phase_adv) begin
            phase_reg <= phase_reg + step_ext;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            left_out_reg  <= left_res_reg;
            right_out_reg <= right_res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(DATA_W-2*SAMPLE_WIDTH){1'b0}}, right_out_reg, left_out_reg};

endmodule
`default_nettype wire

/* rtl/stl_lfo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stl_lfo: low-frequency oscillator value
// Turns the phase into a Q16 oscillator value from 0 to 1.0 (sine table,
// triangle or square) and registers it on request.
// ----------------------------------------------------------------------------
module stl_lfo #(
    parameter int PHASE_WIDTH = 24
) (
    input  wire logic                        aclk,
    input  wire logic [PHASE_WIDTH-1:0]      phase,
    input  wire logic [stl_pkg::SHAPE_W-1:0] wave_shape,
    input  wire logic                        load,
    output logic      [stl_pkg::GAIN_W-1:0]  lfo
);
    import stl_pkg::*;

    localparam int TRI_W = PHASE_WIDTH + GAIN_W;

    logic [GAIN_W-1:0] sine_rom [SINE_DEPTH];
    logic [GAIN_W-1:0] lfo_reg;
    logic [GAIN_W-1:0] lfo_next;
    logic [TRI_W-1:0]  tri_scaled;
    logic [GAIN_W-1:0] twice;
    logic              lower_half;

    // Constant sine table, built at elaboration.
    for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_rom
        assign sine_rom[g] = sine_entry(64'(g));
    end

    // Twice the phase in Q16, truncated.
    assign tri_scaled = {phase, {GAIN_W{1'b0}}};
    assign twice      = tri_scaled[TRI_W-1:PHASE_WIDTH];
    assign lower_half = ~phase[PHASE_WIDTH-1];

    // Shape selection; the unused code behaves as square.
    always_comb begin
        unique case (wave_shape)
            WAVE_SINE:     lfo_next = sine_rom[phase[PHASE_WIDTH-1 -: SINE_IDX_W]];
            WAVE_TRIANGLE: lfo_next = lower_half ? twice : ((ONE_Q16 << 1) - twice);
            default:       lfo_next = lower_half ? ONE_Q16 : '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            lfo_reg <= lfo_next;
        end
    end

    assign lfo = lfo_reg;

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for stereo_tremolo_lfo
// A short table of directed beats and register writes is walked first. It
// covers sample extremes, every oscillator shape at the quarter-cycle phase
// points, depth and step extremes, and bypass. Random phases with fresh
// register settings follow. Every result beat is checked against a pinned
// value or a cycle-free tremolo model, while both stream sides idle and stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int SW      = 24;
    localparam int PW      = 24;
    localparam int TDATA_W = ((2*SW+7)/8)*8;

    // Unused shape code; the block treats it as a square wave.
    localparam logic [stl_pkg::SHAPE_W-1:0] WAVE_UNUSED = 2'd3;

    localparam logic [SW-1:0] S_MAX  = 24'h7FFFFF;
    localparam logic [SW-1:0] S_MIN  = 24'h800000;
    localparam logic [SW-1:0] S_NEG1 = 24'hFFFFFF;
    localparam logic [SW-1:0] S_ONE  = 24'h000001;

    localparam logic [22:0] STEP_MAX     = 23'h7FFFFF;
    localparam logic [22:0] STEP_QUARTER = 23'h400000;
    localparam logic [15:0] DEPTH_FULL   = 16'hFFFF;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Odd sine polynomial coefficients, Q30, by power of the angle.
    localparam logic [63:0] SIN_C1 = 64'd1686629713;
    localparam logic [63:0] SIN_C3 = 64'd693598669;
    localparam logic [63:0] SIN_C5 = 64'd85569306;
    localparam logic [63:0] SIN_C7 = 64'd5026995;
    localparam logic [63:0] SIN_C9 = 64'd172272;

    localparam int RANDOM_PHASES   = 10;
    localparam int PAIRS_PER_PHASE = 65;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 30;

    // Receiver stall patterns.
    localparam logic [1:0] RX_OPEN     = 2'd0;
    localparam logic [1:0] RX_COIN     = 2'd1;
    localparam logic [1:0] RX_PERIODIC = 2'd2;
    localparam logic [1:0] RX_BURSTY   = 2'd3;

    typedef struct packed {
        logic [SW-1:0] right;
        logic [SW-1:0] left;
    } stereo_pair_t;

    typedef struct {
        bit                                 is_write;
        logic [stl_pkg::CFG_INDEX_W-1:0]    index;
        logic [stl_pkg::CFG_DATA_W-1:0]     value;
        stereo_pair_t                       dry;
        bit                                 pinned;
        stereo_pair_t                       wet;
    } stim_row_t;

    // DUT signals, all inputs known from time zero.
    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [TDATA_W-1:0]                  s_tdata   = '0;
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [TDATA_W-1:0]                  m_tdata;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [stl_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [stl_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

    // Typed expectation travelling with the beat on the input side.
    logic         pin_valid = 1'b0;
    stereo_pair_t pin_pair  = '0;

    // Model state and register copies.
    logic [PW-1:0]                  lfo_phase;
    logic [stl_pkg::SHAPE_W-1:0]    cur_shape;
    logic [stl_pkg::DEPTH_W-1:0]    cur_depth;
    logic [stl_pkg::STEP_W-1:0]     cur_step;
    logic                           cur_bypass;
    logic [16:0]                    sine_lut [0:255];

    stereo_pair_t expected_pairs [$];
    stim_row_t    directed_rows [$];

    int pairs_sent    = 0;
    int pairs_done    = 0;
    int bypass_pairs  = 0;
    int reg_writes    = 0;
    int errors        = 0;
    int idle_cycles   = 0;
    int burst_left    = 0;
    bit steady_sender = 1'b0;

    logic [1:0] rx_mode  = RX_OPEN;
    int         rx_cycle = 0;
    int         rx_hold  = 0;

    stereo_tremolo_lfo #(
        .SAMPLE_WIDTH (SW),
        .PHASE_WIDTH  (PW)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tremolo model
    // ------------------------------------------------------------------

    // sin(pi/2 * x) in Q30 for x in Q30 over one quarter turn, Horner form.
    function automatic logic [63:0] sin_quarter_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] acc;
        x2  = (x * x) >> 30;
        acc = SIN_C9;
        acc = SIN_C7 - ((x2 * acc) >> 30);
        acc = SIN_C5 - ((x2 * acc) >> 30);
        acc = SIN_C3 - ((x2 * acc) >> 30);
        acc = SIN_C1 - ((x2 * acc) >> 30);
        acc = (x * acc) >> 30;
        return (acc > Q30_ONE) ? Q30_ONE : acc;
    endfunction

    // Raised sine level for table slot k, Q16 in 0..1.
    function automatic logic [16:0] sine_level(input logic [7:0] k);
        logic [63:0] turn;
        logic [63:0] angle;
        logic [63:0] s;
        logic [63:0] v;
        turn  = {32'd0, k, 24'd0};
        angle = turn[30] ? (Q30_ONE - {34'd0, turn[29:0]}) : {34'd0, turn[29:0]};
        s     = sin_quarter_q30(angle);
        v     = turn[31] ? (Q30_ONE - s) : (Q30_ONE + s);
        v     = (v + (64'd1 << 14)) >> 15;
        return (v > 64'h10000) ? 17'h10000 : v[16:0];
    endfunction

    function automatic logic [16:0] lfo_level(input logic [PW-1:0] ph);
        logic [17:0] ramp;
        case (cur_shape)
            stl_pkg::WAVE_SINE: return sine_lut[ph[PW-1 -: 8]];
            stl_pkg::WAVE_TRIANGLE: begin
                // Rising over the first half cycle, falling over the second.
                ramp = ph[PW-1] ? (18'h20000 - {1'b0, ph[PW-1 -: 17]})
                                : {1'b0, ph[PW-1 -: 17]};
                return ramp[16:0];
            end
            default: return ph[PW-1] ? 17'd0 : 17'h10000;
        endcase
    endfunction

    // Signed sample times Q1.16 gain, floored back to sample width.
    function automatic logic [SW-1:0] scale_sample(input logic [SW-1:0] smp,
                                                   input logic [16:0] gain);
        longint prod;
        prod = longint'($signed(smp)) * longint'({1'b0, gain});
        return SW'(prod >>> 16);
    endfunction

    // Predicts one output pair and advances the oscillator phase, or in bypass returns the input pair.
    function automatic stereo_pair_t modulate_pair(input stereo_pair_t dry);
        stereo_pair_t wet;
        logic [16:0]  lfo;
        logic [16:0]  gain;
        logic [63:0]  dmul;
        if (cur_bypass)
            return dry;
        lfo        = lfo_level(lfo_phase);
        dmul       = 64'(cur_depth) * (64'd65536 - 64'(lfo));
        gain       = 17'(64'd65536 - (dmul >> 17));
        wet.left   = scale_sample(dry.left, gain);
        wet.right  = scale_sample(dry.right, gain);
        lfo_phase  = lfo_phase + PW'(cur_step);
        return wet;
    endfunction

    initial begin
        for (int k = 0; k < 256; k++)
            sine_lut[k] = sine_level(8'(k));
    end

    // ------------------------------------------------------------------
    // Monitor: tracks register writes, predicts each accepted beat and
    // checks each result beat against the oldest prediction.
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input logic [SW-1:0] want,
                                 input logic [SW-1:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
    endtask

    always @(posedge aclk) begin
        stereo_pair_t want;
        stereo_pair_t got;
        if (!aresetn) begin
            lfo_phase  = '0;
            cur_shape  = stl_pkg::WAVE_SHAPE_RST;
            cur_depth  = stl_pkg::DEPTH_RST;
            cur_step   = stl_pkg::PHASE_STEP_RST;
            cur_bypass = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                reg_writes++;
                case (cfg_index)
                    stl_pkg::REG_WAVE_SHAPE: cur_shape  = cfg_data[stl_pkg::SHAPE_W-1:0];
                    stl_pkg::REG_DEPTH:      cur_depth  = cfg_data[stl_pkg::DEPTH_W-1:0];
                    stl_pkg::REG_PHASE_STEP: cur_step   = cfg_data[stl_pkg::STEP_W-1:0];
                    default:                 cur_bypass = cfg_data[0];
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (cur_bypass)
                    bypass_pairs++;
                want = modulate_pair(s_tdata[2*SW-1:0]);
                if (pin_valid)
                    want = pin_pair;
                expected_pairs.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[2*SW-1:0];
                pairs_done++;
                if (expected_pairs.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result beat with nothing expected, actual %h",
                                 $time, got);
                end else begin
                    want = expected_pairs.pop_front();
                    if (got.left !== want.left)
                        note_mismatch("left_out", want.left, got.left);
                    if (got.right !== want.right)
                        note_mismatch("right_out", want.right, got.right);
                end
            end
        end
    end

    // Receiver: backpressure on a stall pattern that is picked again at random periodically.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 150 == 0)
            rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_tready <= (rx_cycle % 5 < 2);
            default: begin
                if (rx_hold != 0) begin
                    rx_hold  <= rx_hold - 1;
                    m_tready <= 1'b0;
                end else begin
                    rx_hold  <= $urandom_range(1, 8);
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic void add_write(input logic [stl_pkg::CFG_INDEX_W-1:0] index,
                                      input logic [stl_pkg::CFG_DATA_W-1:0] value);
        stim_row_t row;
        row          = '{default: '0};
        row.is_write = 1'b1;
        row.index    = index;
        row.value    = value;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pair(input logic [SW-1:0] left, input logic [SW-1:0] right,
                                     input bit pinned, input logic [SW-1:0] left_out,
                                     input logic [SW-1:0] right_out);
        stim_row_t row;
        row           = '{default: '0};
        row.dry.left  = left;
        row.dry.right = right;
        row.pinned    = pinned;
        row.wet.left  = left_out;
        row.wet.right = right_out;
        directed_rows.push_back(row);
    endfunction

    // Presents one input beat and holds it until it is taken.
    task automatic send_pair(input stereo_pair_t dry, input bit pinned,
                             input stereo_pair_t wet);
        s_tvalid  <= 1'b1;
        s_tdata   <= TDATA_W'(dry);
        pin_valid <= pinned;
        pin_pair  <= wet;
        do @(posedge aclk); while (!s_tready);
        pairs_sent++;
    endtask

    // Sender bursts: after a burst, valid drops for a random gap.
    task automatic pace_sender();
        if (steady_sender)
            return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // Stops sending and waits until every result beat is back and the
    // block is ready again.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pairs_done != pairs_sent || !s_tready);
    endtask

    task automatic write_reg(input logic [stl_pkg::CFG_INDEX_W-1:0] index,
                             input logic [stl_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [SW-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2: return S_NEG1;
            3: return '0;
            default: return SW'($urandom());
        endcase
    endfunction

    initial begin
        stim_row_t    row;
        stereo_pair_t dry;
        logic [15:0]  depth_pick;
        logic [22:0]  step_pick;

        // Phase starts at zero: one beat under reset settings, then a step
        // that lands exactly on half a cycle, then quarter steps so each
        // shape is seen at its quarter-cycle points.
        add_pair('0, '0, 1'b1, '0, '0);
        add_write(stl_pkg::REG_PHASE_STEP, 23'd8386913);
        add_pair(S_MAX, S_MIN, 1'b0, '0, '0);
        add_write(stl_pkg::REG_DEPTH, DEPTH_FULL);
        add_write(stl_pkg::REG_PHASE_STEP, STEP_QUARTER);
        for (int shp = 0; shp < 3; shp++) begin
            if (shp == 1)
                add_write(stl_pkg::REG_WAVE_SHAPE, stl_pkg::WAVE_TRIANGLE);
            if (shp == 2)
                add_write(stl_pkg::REG_WAVE_SHAPE, stl_pkg::WAVE_SQUARE);
            add_pair(S_MAX, S_MIN, 1'b0, '0, '0);
            add_pair(S_MIN, S_MAX, 1'b0, '0, '0);
            add_pair(S_NEG1, S_ONE, 1'b0, '0, '0);
            add_pair(S_MAX, S_NEG1, 1'b0, '0, '0);
        end
        add_write(stl_pkg::REG_WAVE_SHAPE, WAVE_UNUSED);
        add_pair(S_MAX, S_MIN, 1'b0, '0, '0);
        add_pair(S_MIN, S_MAX, 1'b0, '0, '0);
        // Zero depth gives unity gain.
        add_write(stl_pkg::REG_DEPTH, '0);
        add_pair(S_MAX, S_MIN, 1'b1, S_MAX, S_MIN);
        add_pair(S_NEG1, S_ONE, 1'b1, S_NEG1, S_ONE);
        // Bypass passes samples through and holds the phase.
        add_write(stl_pkg::REG_PHASE_STEP, STEP_MAX);
        add_write(stl_pkg::REG_BYPASS, 23'd1);
        add_pair(S_MIN, S_MAX, 1'b1, S_MIN, S_MAX);
        add_pair(24'h5A5A5A, 24'hA5A5A5, 1'b1, 24'h5A5A5A, 24'hA5A5A5);
        add_write(stl_pkg::REG_BYPASS, '0);
        add_write(stl_pkg::REG_DEPTH, DEPTH_FULL);
        add_write(stl_pkg::REG_WAVE_SHAPE, stl_pkg::WAVE_SINE);
        add_pair(24'h123456, 24'hEDCBA9, 1'b0, '0, '0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table.
        burst_left = $urandom_range(1, 8);
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_write) begin
                drain();
                write_reg(row.index, row.value);
            end else begin
                send_pair(row.dry, row.pinned, row.wet);
                pace_sender();
            end
        end

        // Random phases, each with its own register settings.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            case ($urandom_range(0, 3))
                0:       depth_pick = '0;
                1:       depth_pick = DEPTH_FULL;
                default: depth_pick = 16'($urandom());
            endcase
            case ($urandom_range(0, 4))
                0:       step_pick = '0;
                1:       step_pick = STEP_MAX;
                2:       step_pick = 23'($urandom_range(1, 4095));
                default: step_pick = 23'($urandom());
            endcase
            write_reg(stl_pkg::REG_WAVE_SHAPE, 23'($urandom_range(0, 3)));
            write_reg(stl_pkg::REG_DEPTH, 23'(depth_pick));
            write_reg(stl_pkg::REG_PHASE_STEP, step_pick);
            write_reg(stl_pkg::REG_BYPASS, 23'($urandom_range(0, 5) == 0));
            steady_sender = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
                // Once mid-run, hold off until the block has emptied.
                if (ph == RANDOM_PHASES / 2 && n == PAIRS_PER_PHASE / 2)
                    drain();
                dry.left  = random_sample();
                dry.right = random_sample();
                send_pair(dry, 1'b0, '0);
                pace_sender();
            end
        end

        // Wait for the last results, then watch for stray beats.
        drain();
        repeat (20) @(posedge aclk);

        $display("Covered %0d sample pairs (%0d in bypass) and %0d register writes,",
                 pairs_sent, bypass_pairs, reg_writes);
        $display("with all four shape codes, depth and step extremes and random stalls.");
        if (errors == 0 && expected_pairs.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            if (expected_pairs.size() != 0)
                $display("%0d expected result beats never arrived", expected_pairs.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/stl_pkg.sv
rtl/stl_lfo.sv
rtl/stereo_tremolo_lfo.sv
sim/tb.sv
